// ===== hdl/nhl_pkg.sv =====
`default_nettype none

package nhl_pkg;

    // Bus and wait counter sizes
    localparam int BUS_WIDTH   = 16;
    localparam int COUNT_WIDTH = 24;

    localparam logic [15:0] BUS_MASK  = 16'((17'd1 << BUS_WIDTH) - 17'd1);
    localparam logic [31:0] COUNT_MAX = 32'((33'd1 << COUNT_WIDTH) - 33'd1);

    // Stream word widths
    localparam int IN_WIDTH  = 56;
    localparam int OUT_WIDTH = 40;

    // Configuration port
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 24;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WIDE_BUS      = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WRITE_CODE    = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_READ_CODE     = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_START_CODE    = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RESET_CODE    = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TIMEOUT_TICKS = 3'd5;

    // Beat counts and first data beat for each bus mode
    localparam logic [2:0] BEATS_WIDE        = 3'd3;
    localparam logic [2:0] BEATS_NIBBLE      = 3'd7;
    localparam logic [2:0] BEATS_SHORT       = 3'd1;
    localparam logic [2:0] FIRST_DATA_WIDE   = 3'd2;
    localparam logic [2:0] FIRST_DATA_NIBBLE = 3'd5;

    // Command codes on the input stream
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_WRITE = 3'd1,
        OP_READ  = 3'd2,
        OP_START = 3'd3,
        OP_RESET = 3'd4
    } op_t;

    // Link sequencer phases
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HIGH    = 2'd1,
        PH_LOW     = 2'd2,
        PH_RELEASE = 2'd3
    } phase_t;

    // Classified tick handed from front to back
    typedef struct packed {
        op_t         op;
        logic [15:0] address;
        logic [15:0] write_data;
        logic        ack_in;
        logic        req_echo_in;
        logic [15:0] bus_in;
    } item_t;

    // Result word, last field in the lowest bits
    typedef struct packed {
        logic [1:0]  pad;
        logic        timeout_error;
        logic [15:0] read_data;
        logic        done_res;
        logic        busy_res;
        logic        bus_drive;
        logic [15:0] bus_out;
        logic        strobe_out;
        logic        req_out;
    } res_t;

endpackage

`default_nettype wire

// ===== hdl/nhl_front.sv =====
`default_nettype none

module nhl_front
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // command, address, write_data, ack_in, req_echo_in, bus_in, zero pad
    input  wire logic [nhl_pkg::IN_WIDTH-1:0] s_tdata,
    output logic                              q_valid,
    output nhl_pkg::item_t                    q_item,
    input  wire logic                         q_pop
);

    nhl_pkg::item_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    nhl_pkg::item_t in_item;
    logic           push;

    // Unpack the word and classify the command
    always_comb
    begin
        in_item.address     = s_tdata[18:3];
        in_item.write_data  = s_tdata[34:19];
        in_item.ack_in      = s_tdata[35];
        in_item.req_echo_in = s_tdata[36];
        in_item.bus_in      = s_tdata[52:37];
        case (s_tdata[2:0])
            3'd1:    in_item.op = nhl_pkg::OP_WRITE;
            3'd2:    in_item.op = nhl_pkg::OP_READ;
            3'd3:    in_item.op = nhl_pkg::OP_START;
            3'd4:    in_item.op = nhl_pkg::OP_RESET;
            default: in_item.op = nhl_pkg::OP_NONE;
        endcase
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Two-word queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/nhl_back.sv =====
`default_nettype none

module nhl_back
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [nhl_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [nhl_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    input  wire logic                                q_valid,
    input  wire nhl_pkg::item_t                      q_item,
    output logic                                     q_pop,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // req_out, strobe_out, bus_out, bus_drive, busy_res, done_res,
    // read_data, timeout_error, zero pad
    output logic [nhl_pkg::OUT_WIDTH-1:0]            m_tdata
);

    // Configuration registers
    logic        wide_bus_reg;
    logic [3:0]  write_code_reg;
    logic [3:0]  read_code_reg;
    logic [3:0]  start_code_reg;
    logic [3:0]  reset_code_reg;
    logic [23:0] timeout_reg;

    // Sequencer state
    nhl_pkg::phase_t                  phase_reg, phase_next;
    nhl_pkg::op_t                     op_reg, op_next;
    logic [2:0]                       beat_reg, beat_next;
    logic [15:0]                      addr_reg, addr_next;
    logic [15:0]                      data_reg, data_next;
    logic [15:0]                      accum_reg, accum_next;
    logic [nhl_pkg::COUNT_WIDTH-1:0]  wait_reg, wait_next;
    logic                             done_next;
    logic                             terr_next;

    logic                             out_valid_reg;
    nhl_pkg::res_t                    out_reg;
    nhl_pkg::res_t                    res_next;

    logic [15:0] bus_m;
    logic [2:0]  first_data;
    logic        rx_now;
    logic [15:0] rx_word;
    logic [31:0] limit;
    logic        limit_hit;
    logic        tx_next;
    logic [2:0]  total_next;
    logic [15:0] word_next;

    function automatic logic [2:0] beats_total(nhl_pkg::op_t op, logic wide);
        logic [2:0] n;
        if (op == nhl_pkg::OP_WRITE || op == nhl_pkg::OP_READ)
        begin
            n = wide ? nhl_pkg::BEATS_WIDE : nhl_pkg::BEATS_NIBBLE;
        end
        else
        begin
            n = nhl_pkg::BEATS_SHORT;
        end
        return n;
    endfunction

    assign q_pop    = q_valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_bus_reg   <= 1'b0;
            write_code_reg <= 4'd1;
            read_code_reg  <= 4'd2;
            start_code_reg <= 4'd3;
            reset_code_reg <= 4'd4;
            timeout_reg    <= 24'd1000000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                nhl_pkg::CFG_WIDE_BUS:      wide_bus_reg   <= cfg_data[0];
                nhl_pkg::CFG_WRITE_CODE:    write_code_reg <= cfg_data[3:0];
                nhl_pkg::CFG_READ_CODE:     read_code_reg  <= cfg_data[3:0];
                nhl_pkg::CFG_START_CODE:    start_code_reg <= cfg_data[3:0];
                nhl_pkg::CFG_RESET_CODE:    reset_code_reg <= cfg_data[3:0];
                nhl_pkg::CFG_TIMEOUT_TICKS: timeout_reg    <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Receive beat and wait limit helpers
    always_comb
    begin
        bus_m      = q_item.bus_in & nhl_pkg::BUS_MASK;
        first_data = wide_bus_reg ? nhl_pkg::FIRST_DATA_WIDE : nhl_pkg::FIRST_DATA_NIBBLE;
        rx_now     = (op_reg == nhl_pkg::OP_READ) && (beat_reg >= first_data);
        if (wide_bus_reg)
        begin
            rx_word = bus_m;
        end
        else if (beat_reg == first_data)
        begin
            rx_word = {8'h00, bus_m[3:0], 4'h0};
        end
        else
        begin
            rx_word = {8'h00, accum_reg[7:4], bus_m[3:0]};
        end

        limit = {8'h00, timeout_reg};
        if (limit == 32'd0)
        begin
            limit = 32'd1;
        end
        if (limit > nhl_pkg::COUNT_MAX)
        begin
            limit = nhl_pkg::COUNT_MAX;
        end
        limit_hit = ({1'b0, 32'(wait_reg)} + 33'd1) >= {1'b0, limit};
    end

    // Next state of the sequencer
    always_comb
    begin
        phase_next = phase_reg;
        op_next    = op_reg;
        beat_next  = beat_reg;
        addr_next  = addr_reg;
        data_next  = data_reg;
        accum_next = accum_reg;
        wait_next  = wait_reg;
        done_next  = 1'b0;
        terr_next  = 1'b0;

        case (phase_reg)
            nhl_pkg::PH_HIGH:
            begin
                if (q_item.ack_in)
                begin
                    if (rx_now)
                    begin
                        accum_next = rx_word;
                    end
                    phase_next = nhl_pkg::PH_LOW;
                    wait_next  = '0;
                end
                else if (limit_hit)
                begin
                    phase_next = nhl_pkg::PH_IDLE;
                    done_next  = 1'b1;
                    terr_next  = 1'b1;
                    wait_next  = '0;
                end
                else
                begin
                    wait_next = wait_reg + {{(nhl_pkg::COUNT_WIDTH-1){1'b0}}, 1'b1};
                end
            end
            nhl_pkg::PH_LOW:
            begin
                if (!q_item.ack_in)
                begin
                    beat_next  = beat_reg + 3'd1;
                    phase_next = nhl_pkg::PH_HIGH;
                    wait_next  = '0;
                end
                else if (limit_hit)
                begin
                    phase_next = nhl_pkg::PH_IDLE;
                    done_next  = 1'b1;
                    terr_next  = 1'b1;
                    wait_next  = '0;
                end
                else
                begin
                    wait_next = wait_reg + {{(nhl_pkg::COUNT_WIDTH-1){1'b0}}, 1'b1};
                end
            end
            nhl_pkg::PH_RELEASE:
            begin
                if (!q_item.req_echo_in)
                begin
                    phase_next = nhl_pkg::PH_IDLE;
                    done_next  = 1'b1;
                    wait_next  = '0;
                end
                else if (limit_hit)
                begin
                    phase_next = nhl_pkg::PH_IDLE;
                    done_next  = 1'b1;
                    terr_next  = 1'b1;
                    wait_next  = '0;
                end
                else
                begin
                    wait_next = wait_reg + {{(nhl_pkg::COUNT_WIDTH-1){1'b0}}, 1'b1};
                end
            end
            default:
            begin
                if (q_item.op != nhl_pkg::OP_NONE)
                begin
                    op_next    = q_item.op;
                    addr_next  = q_item.address;
                    data_next  = q_item.write_data;
                    beat_next  = 3'd0;
                    wait_next  = '0;
                    phase_next = nhl_pkg::PH_HIGH;
                end
            end
        endcase

        // past the last beat (also after a bus width change): release
        total_next = beats_total(op_next, wide_bus_reg);
        if ((phase_next == nhl_pkg::PH_HIGH || phase_next == nhl_pkg::PH_LOW)
            && beat_next >= total_next)
        begin
            phase_next = nhl_pkg::PH_RELEASE;
        end
    end

    // Result word from the new state
    always_comb
    begin
        tx_next = !((op_next == nhl_pkg::OP_READ) && (beat_next >= first_data));

        if (beat_next == 3'd0)
        begin
            case (op_next)
                nhl_pkg::OP_WRITE: word_next = {12'h000, write_code_reg};
                nhl_pkg::OP_READ:  word_next = {12'h000, read_code_reg};
                nhl_pkg::OP_START: word_next = {12'h000, start_code_reg};
                default:           word_next = {12'h000, reset_code_reg};
            endcase
        end
        else if (wide_bus_reg)
        begin
            word_next = (beat_next == 3'd1) ? addr_next : data_next;
        end
        else
        begin
            case (beat_next)
                3'd1:    word_next = {12'h000, addr_next[15:12]};
                3'd2:    word_next = {12'h000, addr_next[11:8]};
                3'd3:    word_next = {12'h000, addr_next[7:4]};
                3'd4:    word_next = {12'h000, addr_next[3:0]};
                3'd5:    word_next = {12'h000, data_next[7:4]};
                default: word_next = {12'h000, data_next[3:0]};
            endcase
        end
        word_next = word_next & nhl_pkg::BUS_MASK;

        res_next               = '0;
        res_next.done_res      = done_next;
        res_next.timeout_error = terr_next;
        res_next.read_data     = accum_next;
        case (phase_next)
            nhl_pkg::PH_HIGH, nhl_pkg::PH_LOW:
            begin
                res_next.req_out    = 1'b1;
                res_next.busy_res   = 1'b1;
                res_next.strobe_out = (phase_next == nhl_pkg::PH_HIGH);
                if (tx_next)
                begin
                    res_next.bus_drive = 1'b1;
                    res_next.bus_out   = word_next;
                end
            end
            nhl_pkg::PH_RELEASE:
            begin
                res_next.busy_res = 1'b1;
            end
            default:
            begin
                res_next.busy_res = 1'b0;
            end
        endcase
    end

    // State update, one tick per popped word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= nhl_pkg::PH_IDLE;
            op_reg        <= nhl_pkg::OP_NONE;
            beat_reg      <= 3'd0;
            addr_reg      <= 16'd0;
            data_reg      <= 16'd0;
            accum_reg     <= 16'd0;
            wait_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg <= phase_next;
                op_reg    <= op_next;
                beat_reg  <= beat_next;
                addr_reg  <= addr_next;
                data_reg  <= data_next;
                accum_reg <= accum_next;
                wait_reg  <= wait_next;
            end
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_reg <= res_next;
        end
    end

`ifndef SYNTHESIS
    a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == nhl_pkg::PH_IDLE |-> wait_reg == '0)
        else $error("wait counter not cleared in idle");

    a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (!out_reg.done_res || phase_reg == nhl_pkg::PH_IDLE))
        else $error("done reported while a transaction continues");

    a_busy_tracks_phase: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> out_reg.busy_res == (phase_reg != nhl_pkg::PH_IDLE))
        else $error("busy flag disagrees with sequencer phase");

    a_bus_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.bus_drive |-> out_reg.bus_out == 16'd0)
        else $error("bus value shown while not driving");
`endif

endmodule

`default_nettype wire

// ===== hdl/nibble_handshake_link_master.sv =====
// Request/strobe/acknowledge link master, host side.
// Each input word is one sampling tick of the link: an optional command
// (write, read, start, reset) with address and data, plus the sampled ack,
// request echo and bus lines. Each output word gives the line values to
// drive for that tick together with busy, done, read data and timeout.
// One word in gives exactly one word out, in order.
// Throughput: one word per cycle while the output register is free or the
// receiver takes it. The front classifies the command and holds up to two
// words in a queue; the back sequencer updates its state and loads the
// output register for each word it pops. An accepted word passes a queue
// entry, then the output register, and leaves when m_tready is high.
// When the receiver stalls, the output register holds its word, the queue
// fills, and s_tready drops once both queue entries are taken.
// Reset clears the queue and output valid, returns the sequencer to idle
// and loads the default command codes, nibble bus mode and the timeout.
// Configuration: cfg_we writes cfg_data into register cfg_index (wide_bus,
// write, read, start, reset codes, timeout ticks); write only while idle.
`default_nettype none

module nibble_handshake_link_master
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [nhl_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [nhl_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // command, address, write_data, ack_in, req_echo_in, bus_in, zero pad
    input  wire logic [nhl_pkg::IN_WIDTH-1:0]        s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // req_out, strobe_out, bus_out, bus_drive, busy_res, done_res,
    // read_data, timeout_error, zero pad
    output logic [nhl_pkg::OUT_WIDTH-1:0]            m_tdata
);

    logic           q_valid;
    logic           q_pop;
    nhl_pkg::item_t q_item;

    // Accept and classify
    nhl_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // Link sequencer and result register
    nhl_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 5000;

    // One link tick as it travels on s_tdata, command in the lowest bits
    typedef struct packed {
        logic [15:0] bus;
        logic        echo;
        logic        ack;
        logic [15:0] wdata;
        logic [15:0] addr;
        logic [2:0]  cmd;
    } tick_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_we = 1'b0;
    logic [nhl_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [nhl_pkg::CFG_DATA_WIDTH-1:0]  cfg_data = '0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [nhl_pkg::IN_WIDTH-1:0]        s_tdata = '0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [nhl_pkg::OUT_WIDTH-1:0]       m_tdata;

    // Line values still owed by the block, oldest first
    nhl_pkg::res_t expected_words[$];
    int   mismatch_count = 0;
    int   words_checked = 0;
    int   quiet_cycles = 0;

    // Traffic shaping
    int gap_pct = 31;
    int stall_pct = 31;
    int ack_rise_pct = 70;
    int ack_fall_pct = 70;
    int echo_fall_pct = 60;

    // Shadow of the link master: configuration
    logic        wide_mode = 1'b0;
    logic [3:0]  code_write = 4'd1;
    logic [3:0]  code_read = 4'd2;
    logic [3:0]  code_start = 4'd3;
    logic [3:0]  code_reset = 4'd4;
    logic [23:0] wait_ticks = 24'd1000000;

    // Shadow of the link master: sequencer
    nhl_pkg::phase_t lk_phase = nhl_pkg::PH_IDLE;
    nhl_pkg::op_t    lk_op = nhl_pkg::OP_NONE;
    logic [2:0]      lk_beat = 3'd0;
    logic [15:0]     lk_addr = 16'h0;
    logic [15:0]     lk_data = 16'h0;
    logic [15:0]     lk_read = 16'h0;
    int unsigned     lk_wait = 0;

    always #1 clk = ~clk;

    nibble_handshake_link_master i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Number of beats in the current transaction
    function automatic logic [2:0] link_beats();
        if (lk_op == nhl_pkg::OP_WRITE || lk_op == nhl_pkg::OP_READ)
        begin
            return wide_mode ? nhl_pkg::BEATS_WIDE : nhl_pkg::BEATS_NIBBLE;
        end
        return nhl_pkg::BEATS_SHORT;
    endfunction

    function automatic logic link_receives(input logic [2:0] idx);
        return (lk_op == nhl_pkg::OP_READ) &&
               (idx >= (wide_mode ? nhl_pkg::FIRST_DATA_WIDE : nhl_pkg::FIRST_DATA_NIBBLE));
    endfunction

    // Bus value sent on a beat: code, address, then data
    function automatic logic [15:0] link_word(input logic [2:0] idx);
        logic [15:0] w;
        if (idx == 3'd0)
        begin
            case (lk_op)
                nhl_pkg::OP_WRITE: w = {12'h0, code_write};
                nhl_pkg::OP_READ:  w = {12'h0, code_read};
                nhl_pkg::OP_START: w = {12'h0, code_start};
                default:           w = {12'h0, code_reset};
            endcase
        end
        else if (wide_mode)
        begin
            w = (idx == 3'd1) ? lk_addr : lk_data;
        end
        else if (idx <= 3'd4)
        begin
            w = (lk_addr >> (4 * (4 - int'(idx)))) & 16'h000f;
        end
        else if (idx == 3'd5)
        begin
            w = {12'h0, lk_data[7:4]};
        end
        else
        begin
            w = {12'h0, lk_data[3:0]};
        end
        return w & nhl_pkg::BUS_MASK;
    endfunction

    // One unmet wait tick; true when the limit is hit
    function automatic logic link_wait_expired();
        int unsigned limit;
        limit = (wait_ticks == 24'd0) ? 32'd1 : {8'h0, wait_ticks};
        if (limit > nhl_pkg::COUNT_MAX)
            limit = nhl_pkg::COUNT_MAX;
        if (lk_wait + 1 >= limit)
            return 1'b1;
        lk_wait++;
        return 1'b0;
    endfunction

    // Advance the shadow sequencer by one tick and give the line values
    function automatic nhl_pkg::res_t link_tick(input tick_t t);
        nhl_pkg::res_t r;
        logic [15:0]   bus;
        r   = '0;
        bus = t.bus & nhl_pkg::BUS_MASK;
        case (lk_phase)
            nhl_pkg::PH_HIGH:
            begin
                if (t.ack)
                begin
                    if (link_receives(lk_beat))
                    begin
                        if (wide_mode)
                            lk_read = bus;
                        else if (lk_beat == nhl_pkg::FIRST_DATA_NIBBLE)
                            lk_read = {8'h0, bus[3:0], 4'h0};
                        else
                            lk_read = {8'h0, lk_read[7:4], bus[3:0]};
                    end
                    lk_phase = nhl_pkg::PH_LOW;
                    lk_wait  = 0;
                end
                else if (link_wait_expired())
                begin
                    lk_phase        = nhl_pkg::PH_IDLE;
                    r.done_res      = 1'b1;
                    r.timeout_error = 1'b1;
                    lk_wait         = 0;
                end
            end
            nhl_pkg::PH_LOW:
            begin
                if (!t.ack)
                begin
                    lk_beat  = lk_beat + 3'd1;
                    lk_phase = (lk_beat >= link_beats()) ? nhl_pkg::PH_RELEASE
                                                         : nhl_pkg::PH_HIGH;
                    lk_wait  = 0;
                end
                else if (link_wait_expired())
                begin
                    lk_phase        = nhl_pkg::PH_IDLE;
                    r.done_res      = 1'b1;
                    r.timeout_error = 1'b1;
                    lk_wait         = 0;
                end
            end
            nhl_pkg::PH_RELEASE:
            begin
                if (!t.echo)
                begin
                    lk_phase   = nhl_pkg::PH_IDLE;
                    r.done_res = 1'b1;
                    lk_wait    = 0;
                end
                else if (link_wait_expired())
                begin
                    lk_phase        = nhl_pkg::PH_IDLE;
                    r.done_res      = 1'b1;
                    r.timeout_error = 1'b1;
                    lk_wait         = 0;
                end
            end
            default:
            begin
                lk_phase = nhl_pkg::PH_IDLE;
                if (t.cmd >= nhl_pkg::OP_WRITE && t.cmd <= nhl_pkg::OP_RESET)
                begin
                    lk_op    = nhl_pkg::op_t'(t.cmd);
                    lk_addr  = t.addr;
                    lk_data  = t.wdata;
                    lk_beat  = 3'd0;
                    lk_wait  = 0;
                    lk_phase = nhl_pkg::PH_HIGH;
                end
            end
        endcase

        // A width change can leave the index past the last beat
        if ((lk_phase == nhl_pkg::PH_HIGH || lk_phase == nhl_pkg::PH_LOW)
            && lk_beat >= link_beats())
            lk_phase = nhl_pkg::PH_RELEASE;

        if (lk_phase == nhl_pkg::PH_HIGH || lk_phase == nhl_pkg::PH_LOW)
        begin
            r.req_out    = 1'b1;
            r.busy_res   = 1'b1;
            r.strobe_out = (lk_phase == nhl_pkg::PH_HIGH);
            if (!link_receives(lk_beat))
            begin
                r.bus_drive = 1'b1;
                r.bus_out   = link_word(lk_beat);
            end
        end
        else if (lk_phase == nhl_pkg::PH_RELEASE)
        begin
            r.busy_res = 1'b1;
        end
        r.read_data = lk_read;
        return r;
    endfunction

    function automatic tick_t make_tick(input logic [2:0] cmd, input logic [15:0] addr,
                                        input logic [15:0] wdata, input logic ack,
                                        input logic echo, input logic [15:0] bus);
        return {bus, echo, ack, wdata, addr, cmd};
    endfunction

    // Remote side that answers according to where the sequencer stands
    function automatic tick_t random_tick();
        tick_t t;
        int    pick;
        t.addr  = 16'($urandom);
        t.wdata = 16'($urandom);
        t.bus   = 16'($urandom);
        t.ack   = 1'($urandom_range(1));
        t.echo  = 1'($urandom_range(1));
        t.cmd   = 3'($urandom_range(7));
        case (lk_phase)
            nhl_pkg::PH_HIGH:    t.ack  = ($urandom_range(99) < ack_rise_pct);
            nhl_pkg::PH_LOW:     t.ack  = !($urandom_range(99) < ack_fall_pct);
            nhl_pkg::PH_RELEASE: t.echo = !($urandom_range(99) < echo_fall_pct);
            default:
            begin
                pick = $urandom_range(99);
                if (pick < 6)
                    t.cmd = nhl_pkg::OP_NONE;
                else if (pick < 12)
                    t.cmd = 3'($urandom_range(7, 5));
                else
                    t.cmd = 3'($urandom_range(nhl_pkg::OP_RESET, nhl_pkg::OP_WRITE));
            end
        endcase
        return t;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch on word %0d: %s", $realtime, words_checked, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // Send one tick, with random gaps ahead of it
    task automatic send_tick(input tick_t t);
        while ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, t};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_words.push_back(link_tick(t));
    endtask

    // Stop sending and let every owed word come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [nhl_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [nhl_pkg::CFG_DATA_WIDTH-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            nhl_pkg::CFG_WIDE_BUS:      wide_mode  = value[0];
            nhl_pkg::CFG_WRITE_CODE:    code_write = value[3:0];
            nhl_pkg::CFG_READ_CODE:     code_read  = value[3:0];
            nhl_pkg::CFG_START_CODE:    code_start = value[3:0];
            nhl_pkg::CFG_RESET_CODE:    code_reset = value[3:0];
            nhl_pkg::CFG_TIMEOUT_TICKS: wait_ticks = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic configure(input logic wide, input logic [3:0] wc, input logic [3:0] rc,
                             input logic [3:0] sc, input logic [3:0] xc,
                             input logic [23:0] ticks);
        wait_drained();
        write_reg(nhl_pkg::CFG_WIDE_BUS, {23'h0, wide});
        write_reg(nhl_pkg::CFG_WRITE_CODE, {20'h0, wc});
        write_reg(nhl_pkg::CFG_READ_CODE, {20'h0, rc});
        write_reg(nhl_pkg::CFG_START_CODE, {20'h0, sc});
        write_reg(nhl_pkg::CFG_RESET_CODE, {20'h0, xc});
        write_reg(nhl_pkg::CFG_TIMEOUT_TICKS, ticks);
    endtask

    // Prompt (or silent) remote until the transaction ends or reaches a beat
    task automatic respond_until(input logic [15:0] bus, input logic [2:0] stop_beat,
                                 input logic responsive);
        tick_t t;
        while (lk_phase != nhl_pkg::PH_IDLE
               && !(lk_phase == nhl_pkg::PH_HIGH && lk_beat == stop_beat))
        begin
            t.cmd   = 3'($urandom_range(7));
            t.addr  = 16'($urandom);
            t.wdata = 16'($urandom);
            t.bus   = bus;
            t.ack   = responsive && (lk_phase == nhl_pkg::PH_HIGH);
            t.echo  = !responsive;
            send_tick(t);
        end
    endtask

    // Directed: quiet ticks, each operation, field extremes, abort
    task automatic test_link_basics();
        send_tick(make_tick(nhl_pkg::OP_NONE, 16'hffff, 16'hffff, 1'b1, 1'b1, 16'hffff));
        send_tick(make_tick(3'd7, 16'hffff, 16'hffff, 1'b1, 1'b1, 16'hffff));
        // handshake lines high on the accept tick are not looked at
        send_tick(make_tick(nhl_pkg::OP_WRITE, 16'hffff, 16'hffff, 1'b1, 1'b1, 16'hffff));
        respond_until(16'hffff, 3'd7, 1'b1);

        configure(1'b1, 4'hf, 4'h0, 4'hf, 4'h0, 24'd1000000);
        send_tick(make_tick(nhl_pkg::OP_READ, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000));
        respond_until(16'hffff, 3'd7, 1'b1);
        send_tick(make_tick(nhl_pkg::OP_START, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000));
        respond_until(16'h0000, 3'd7, 1'b1);

        // silent remote, a zero limit acts as a single tick
        configure(1'b0, 4'h1, 4'h2, 4'h3, 4'h4, 24'd0);
        send_tick(make_tick(nhl_pkg::OP_RESET, 16'h8001, 16'h0180, 1'b0, 1'b0, 16'h0000));
        respond_until(16'h0000, 3'd7, 1'b0);
    endtask

    // Directed: bus width changed in the middle of a transaction
    task automatic test_width_change();
        configure(1'b0, 4'h1, 4'h2, 4'h3, 4'h4, 24'd1000000);
        // widened at the first data beat: index already past the wide sequence
        send_tick(make_tick(nhl_pkg::OP_WRITE, 16'h1234, 16'h00a5, 1'b0, 1'b1, 16'h0000));
        respond_until(16'h0000, 3'd5, 1'b1);
        wait_drained();
        write_reg(nhl_pkg::CFG_WIDE_BUS, 24'd1);
        respond_until(16'h0000, 3'd7, 1'b1);

        // narrowed after the address word: goes on with nibble beats
        send_tick(make_tick(nhl_pkg::OP_READ, 16'hbeef, 16'h0000, 1'b0, 1'b1, 16'h5a5a));
        respond_until(16'h5a5a, 3'd2, 1'b1);
        wait_drained();
        write_reg(nhl_pkg::CFG_WIDE_BUS, 24'd0);
        respond_until(16'hc3c3, 3'd7, 1'b1);
    endtask

    // Random: several register settings, remote with random timing
    task automatic test_random_link();
        int phase_no;
        int n;
        for (phase_no = 0; phase_no < 6; phase_no++)
        begin
            case (phase_no)
                0: configure(1'b0, 4'h1, 4'h2, 4'h3, 4'h4, 24'd1000000);
                1: configure(1'b1, 4'h0, 4'hf, 4'h0, 4'hf, 24'd2);
                2: configure(1'b0, 4'hf, 4'h0, 4'hf, 4'h0, 24'd0);
                3: configure(1'b1, 4'($urandom), 4'($urandom), 4'($urandom),
                             4'($urandom), 24'hffffff);
                4: configure(1'b0, 4'($urandom), 4'($urandom), 4'($urandom),
                             4'($urandom), 24'($urandom_range(6, 1)));
                default: configure(1'($urandom_range(1)), 4'($urandom), 4'($urandom),
                                   4'($urandom), 4'($urandom), 24'd3);
            endcase
            ack_rise_pct  = $urandom_range(95, 45);
            ack_fall_pct  = $urandom_range(95, 45);
            echo_fall_pct = $urandom_range(90, 40);
            // one long stretch with no gaps and no stalls
            gap_pct   = (phase_no == 3) ? 0 : 31;
            stall_pct = (phase_no == 3) ? 0 : 31;
            for (n = 0; n < 290; n++)
            begin
                if (phase_no == 2 && n == 145)
                    wait_drained();
                send_tick(random_tick());
            end
        end
        gap_pct   = 31;
        stall_pct = 31;
    endtask

    // Receiver stalls
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // Compare each word leaving the block with the oldest one owed
    always @(posedge clk)
    begin : check_results
        nhl_pkg::res_t got;
        nhl_pkg::res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = nhl_pkg::res_t'(m_tdata);
            if (expected_words.size() == 0)
            begin
                report_mismatch("word with none owed");
            end
            else
            begin
                want = expected_words.pop_front();
                check_field("req_out", 16'(got.req_out), 16'(want.req_out));
                check_field("strobe_out", 16'(got.strobe_out), 16'(want.strobe_out));
                check_field("bus_out", got.bus_out, want.bus_out);
                check_field("bus_drive", 16'(got.bus_drive), 16'(want.bus_drive));
                check_field("busy_res", 16'(got.busy_res), 16'(want.busy_res));
                check_field("done_res", 16'(got.done_res), 16'(want.done_res));
                check_field("read_data", got.read_data, want.read_data);
                check_field("timeout_error", 16'(got.timeout_error),
                            16'(want.timeout_error));
                check_field("pad", 16'(got.pad), 16'(want.pad));
            end
            words_checked++;
        end
    end

    // Watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_link_basics();
        test_width_change();
        test_random_link();
        wait_drained();
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
